// ----- src/bfc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_pkg: shared definitions for the triangle backface cull
// Coordinate width default, pipeline depth, register indexes, flag bit
// positions and the per-item tag that travels beside the datapath.
// ----------------------------------------------------------------------------
package bfc_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    // front, two cross-product stages, three dot-product stages, output
    localparam int NUM_STAGES = 7;

    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAM_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAM_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAM_Z = 2'd2;

    localparam int POLY_FLAGS_W = 3;
    localparam int FLAG_ACTIVE  = 0;
    localparam int FLAG_CLIPPED = 1;
    localparam int FLAG_BACK    = 2;

    localparam int IN_USER_W    = POLY_FLAGS_W + 2;
    localparam int TSEL_TWO     = POLY_FLAGS_W;
    localparam int TSEL_CULLED  = POLY_FLAGS_W + 1;

    localparam int OUT_DATA_W   = 8;
    localparam int OUT_USER_W   = 1;

    typedef struct packed {
        logic test;      // dot-product test applies to this item
        logic old_back;  // incoming backface flag
    } bfc_tag_t;

endpackage

// ----- src/bfc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_front: camera registers and edge / view vectors
// Holds the camera position and registers u = v1-v0, w = v2-v0, e = cam-v0.
// ----------------------------------------------------------------------------
module bfc_front #(
    parameter int COORD_WIDTH = bfc_pkg::COORD_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [bfc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [COORD_WIDTH-1:0]             cfg_wdata,
    input  logic                               en,
    input  logic signed [COORD_WIDTH-1:0]      v0 [3],
    input  logic signed [COORD_WIDTH-1:0]      v1 [3],
    input  logic signed [COORD_WIDTH-1:0]      v2 [3],
    output logic signed [COORD_WIDTH:0]        u_reg [3],
    output logic signed [COORD_WIDTH:0]        w_reg [3],
    output logic signed [COORD_WIDTH:0]        e_reg [3]
);
    import bfc_pkg::*;

    localparam int W = COORD_WIDTH;

    logic signed [W-1:0] cam_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                cam_reg[k] <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_CAM_X: cam_reg[0] <= cfg_wdata;
                CFG_CAM_Y: cam_reg[1] <= cfg_wdata;
                CFG_CAM_Z: cam_reg[2] <= cfg_wdata;
                default: ;  // no register there: drop the write
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                u_reg[k] <= {v1[k][W-1], v1[k]} - {v0[k][W-1], v0[k]};
                w_reg[k] <= {v2[k][W-1], v2[k]} - {v0[k][W-1], v0[k]};
                e_reg[k] <= {cam_reg[k][W-1], cam_reg[k]} - {v0[k][W-1], v0[k]};
            end
        end
    end

endmodule

// ----- src/bfc_cross.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_cross: normal vector n = u x w
// Stage one forms the six products, stage two the three differences.
// The view vector rides along to stay aligned with n.
// ----------------------------------------------------------------------------
module bfc_cross #(
    parameter int COORD_WIDTH = bfc_pkg::COORD_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic [1:0]                         en,
    input  logic signed [COORD_WIDTH:0]        u [3],
    input  logic signed [COORD_WIDTH:0]        w [3],
    input  logic signed [COORD_WIDTH:0]        e [3],
    output logic signed [2*COORD_WIDTH+2:0]    n_reg [3],
    output logic signed [COORD_WIDTH:0]        e_out_reg [3]
);
    import bfc_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    logic signed [PW-1:0] pa_reg [3];
    logic signed [PW-1:0] pb_reg [3];
    logic signed [DW-1:0] e_d_reg [3];

    // n[k] = u[k+1]*w[k+2] - u[k+2]*w[k+1], indexes mod 3
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int k = 0; k < 3; k++) begin
                pa_reg[k]  <= u[(k + 1) % 3] * w[(k + 2) % 3];
                pb_reg[k]  <= u[(k + 2) % 3] * w[(k + 1) % 3];
                e_d_reg[k] <= e[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int k = 0; k < 3; k++) begin
                n_reg[k]     <= {pa_reg[k][PW-1], pa_reg[k]} - {pb_reg[k][PW-1], pb_reg[k]};
                e_out_reg[k] <= e_d_reg[k];
            end
        end
    end

endmodule

// ----- src/bfc_dot.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfc_dot: exact dot product d = n . e
// Each n component is split in a low unsigned half and a high signed half;
// stage one multiplies both halves by e, stage two recombines them, stage
// three adds the three components.
// ----------------------------------------------------------------------------
module bfc_dot #(
    parameter int COORD_WIDTH = bfc_pkg::COORD_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic [2:0]                         en,
    input  logic signed [2*COORD_WIDTH+2:0]    n [3],
    input  logic signed [COORD_WIDTH:0]        e [3],
    output logic signed [3*COORD_WIDTH+5:0]    d_reg
);
    import bfc_pkg::*;

    localparam int DW  = COORD_WIDTH + 1;
    localparam int NW  = 2 * COORD_WIDTH + 3;
    localparam int LW  = NW / 2;
    localparam int HW  = NW - LW;
    localparam int LPW = LW + 1 + DW;
    localparam int HPW = HW + DW;
    localparam int CW  = NW + DW;
    localparam int SW  = CW + 2;

    logic signed [LPW-1:0] lo_reg [3];
    logic signed [HPW-1:0] hi_reg [3];
    logic signed [CW-1:0]  c_reg  [3];

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int k = 0; k < 3; k++) begin
                lo_reg[k] <= $signed({1'b0, n[k][LW-1:0]}) * e[k];
                hi_reg[k] <= $signed(n[k][NW-1:LW]) * e[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int k = 0; k < 3; k++) begin
                c_reg[k] <= (CW'(hi_reg[k]) <<< LW) + CW'(lo_reg[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            d_reg <= SW'(c_reg[0]) + SW'(c_reg[1]) + SW'(c_reg[2]);
        end
    end

endmodule

// ----- src/triangle_backface_cull.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_backface_cull: streaming backface test for one triangle per item
//
// Input channel s_axis_*: one triangle per item, nine signed Q16.8
// coordinates in tdata and the polygon flags, two-sided mark and object
// culled flag in tuser. Output channel m_axis_*: one result item per input
// item, in order: the updated backface flag in tdata, was_tested in tuser.
// Camera position: cfg_we / cfg_addr / cfg_wdata, index 0..2 = x, y, z, others
// dropped; the user must load it while the block is idle, which is not enforced.
//
// Throughput: one item per cycle while the output is not stalled. The
// accepting edge loads the first of seven register stages (front, two
// cross-product stages, three dot-product stages, output register), and
// output valid rises when the item reaches the output register. Every item,
// tested or skipped, walks the full pipe so results stay in order.
// Stall: each stage advances when it is empty or the stage after it moves,
// so bubbles collapse and the input keeps accepting items until the pipe
// is full behind a stalled output.
// Reset: clears all stage valid bits and the camera registers to zero.
// ----------------------------------------------------------------------------
module triangle_backface_cull #(
    parameter int COORD_WIDTH = bfc_pkg::COORD_WIDTH_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // configuration write port
    input  logic                                      cfg_we,
    input  logic [bfc_pkg::CFG_ADDR_W-1:0]            cfg_addr,
    input  logic [COORD_WIDTH-1:0]                    cfg_wdata,
    // input channel
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata, low bit up: v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    // zero fill to whole bytes
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    // tuser, low bit up: poly_flags[2:0], two_sided, object_culled
    input  logic [bfc_pkg::IN_USER_W-1:0]             s_axis_tuser,
    // output channel
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // tdata, low bit up: backface_out, zero fill
    output logic [bfc_pkg::OUT_DATA_W-1:0]            m_axis_tdata,
    // tuser, low bit up: was_tested
    output logic [bfc_pkg::OUT_USER_W-1:0]            m_axis_tuser
);
    import bfc_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int NW = 2 * W + 3;
    localparam int SW = 3 * W + 6;
    localparam int LAST = NUM_STAGES - 1;

    // pipeline control
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_en;
    bfc_tag_t              tag_reg [LAST];
    bfc_tag_t              tag_in;

    // datapath
    logic signed [W-1:0]   v0 [3];
    logic signed [W-1:0]   v1 [3];
    logic signed [W-1:0]   v2 [3];
    logic signed [DW-1:0]  u  [3];
    logic signed [DW-1:0]  w  [3];
    logic signed [DW-1:0]  e  [3];
    logic signed [NW-1:0]  n  [3];
    logic signed [DW-1:0]  e_n [3];
    logic signed [SW-1:0]  d;

    logic                  back_next;
    logic                  back_reg;
    logic                  tested_reg;

    // unpack the coordinates
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            v0[k] = s_axis_tdata[k*W +: W];
            v1[k] = s_axis_tdata[(3+k)*W +: W];
            v2[k] = s_axis_tdata[(6+k)*W +: W];
        end
    end

    // decide up front whether the test applies; skipped items keep their flag
    always_comb begin
        tag_in.old_back = s_axis_tuser[FLAG_BACK];
        tag_in.test     = !s_axis_tuser[TSEL_CULLED] && s_axis_tuser[FLAG_ACTIVE] &&
                          !s_axis_tuser[FLAG_CLIPPED] && !s_axis_tuser[TSEL_TWO] &&
                          !s_axis_tuser[FLAG_BACK];
    end

    // stage i may load when it is empty or its contents move on this cycle
    always_comb begin
        stage_en[LAST] = !valid_reg[LAST] || m_axis_tready;
        for (int i = LAST - 1; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
    end

    assign s_axis_tready = stage_en[0];

    // advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // carry the per-item tag alongside the arithmetic
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            tag_reg[0] <= tag_in;
        end
        for (int i = 1; i < LAST; i++) begin
            if (stage_en[i]) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    bfc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .en        (stage_en[0]),
        .v0        (v0),
        .v1        (v1),
        .v2        (v2),
        .u_reg     (u),
        .w_reg     (w),
        .e_reg     (e)
    );

    bfc_cross #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cross (
        .aclk      (aclk),
        .en        (stage_en[2:1]),
        .u         (u),
        .w         (w),
        .e         (e),
        .n_reg     (n),
        .e_out_reg (e_n)
    );

    bfc_dot #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
        .aclk  (aclk),
        .en    (stage_en[5:3]),
        .n     (n),
        .e     (e_n),
        .d_reg (d)
    );

    // backface when the view dot product is zero or negative
    always_comb begin
        if (tag_reg[LAST-1].test) begin
            back_next = d[SW-1] || (d == '0);
        end else begin
            back_next = tag_reg[LAST-1].old_back;
        end
    end

    // output register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (stage_en[LAST]) begin
            back_reg   <= back_next;
            tested_reg <= tag_reg[LAST-1].test;
        end
    end

    assign m_axis_tvalid = valid_reg[LAST];
    assign m_axis_tdata  = {(OUT_DATA_W-1)'(0), back_reg};
    assign m_axis_tuser  = tested_reg;

endmodule

// ----- test/triangle_backface_cull_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_backface_cull_tb: self-checking bench for the backface cull
// Streams triangles into the block with random source gaps and sink stalls,
// predicts each verdict with exact 128-bit signed arithmetic and compares
// every result item, in order, against the predicted backface and
// was_tested flags. The camera is reloaded between phases while idle.
// ----------------------------------------------------------------------------
module triangle_backface_cull_tb;
    import bfc_pkg::*;

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int IN_DATA_W    = ((9 * CW + 7) / 8) * 8;
    localparam int ONE          = 256;                  // 1.0 in Q16.8
    localparam int C_MAX        = (1 << (CW - 1)) - 1;
    localparam int C_MIN        = -(1 << (CW - 1));
    localparam int IDLE_PCT     = 14;
    localparam int PHASE_ITEMS  = 280;
    localparam int NUM_PHASES   = 6;
    localparam int LIMIT_CYCLES = 200000;

    // register index with no register behind it; writes must be dropped
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [POLY_FLAGS_W-1:0] FL_NONE    = '0;
    localparam logic [POLY_FLAGS_W-1:0] FL_ACTIVE  = POLY_FLAGS_W'(1 << FLAG_ACTIVE);
    localparam logic [POLY_FLAGS_W-1:0] FL_CLIPPED = POLY_FLAGS_W'(1 << FLAG_CLIPPED);
    localparam logic [POLY_FLAGS_W-1:0] FL_BACK    = POLY_FLAGS_W'(1 << FLAG_BACK);

    // first member is the most significant, so x lands in the low bits
    typedef struct packed {
        logic signed [CW-1:0] z, y, x;
    } vertex_t;

    typedef struct packed {
        logic                    object_culled;
        logic                    two_sided;
        logic [POLY_FLAGS_W-1:0] poly_flags;
        vertex_t                 v2, v1, v0;
    } triangle_t;

    typedef struct packed {
        logic backface;
        logic tested;
    } verdict_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds its own camera copy and the verdicts still owed
    // ------------------------------------------------------------------------
    class cull_scoreboard;
        logic signed [CW-1:0] cam_x, cam_y, cam_z;
        verdict_t             owed_verdicts[$];
        int                   errors;

        function new();
            cam_x  = '0;
            cam_y  = '0;
            cam_z  = '0;
            errors = 0;
        endfunction

        function void set_camera(logic [CFG_ADDR_W-1:0] addr, logic [CW-1:0] value);
            case (addr)
                CFG_CAM_X: cam_x = value;
                CFG_CAM_Y: cam_y = value;
                CFG_CAM_Z: cam_z = value;
                default: ;
            endcase
        endfunction

        function verdict_t judge(triangle_t t);
            verdict_t r;
            logic signed [127:0] ux, uy, uz, wx, wy, wz, ex, ey, ez;
            logic signed [127:0] nx, ny, nz, dot;
            r.tested = !(t.object_culled || !t.poly_flags[FLAG_ACTIVE] ||
                         t.poly_flags[FLAG_CLIPPED] || t.two_sided ||
                         t.poly_flags[FLAG_BACK]);
            r.backface = t.poly_flags[FLAG_BACK];
            if (r.tested) begin
                ux = $signed(t.v1.x) - $signed(t.v0.x);
                uy = $signed(t.v1.y) - $signed(t.v0.y);
                uz = $signed(t.v1.z) - $signed(t.v0.z);
                wx = $signed(t.v2.x) - $signed(t.v0.x);
                wy = $signed(t.v2.y) - $signed(t.v0.y);
                wz = $signed(t.v2.z) - $signed(t.v0.z);
                ex = $signed(cam_x) - $signed(t.v0.x);
                ey = $signed(cam_y) - $signed(t.v0.y);
                ez = $signed(cam_z) - $signed(t.v0.z);
                nx = uy * wz - uz * wy;
                ny = uz * wx - ux * wz;
                nz = ux * wy - uy * wx;
                dot = nx * ex + ny * ey + nz * ez;
                r.backface = (dot <= 0);
            end
            return r;
        endfunction

        function void note_triangle(triangle_t t);
            owed_verdicts.push_back(judge(t));
        endfunction

        function void check_result(logic backface, logic tested);
            verdict_t want;
            if (owed_verdicts.size() == 0) begin
                $display("%0t: unexpected result item: backface %0b was_tested %0b",
                         $time, backface, tested);
                errors++;
            end else begin
                want = owed_verdicts.pop_front();
                if (backface !== want.backface) begin
                    $display("%0t: backface_out mismatch: expected %0b actual %0b",
                             $time, want.backface, backface);
                    errors++;
                end
                if (tested !== want.tested) begin
                    $display("%0t: was_tested mismatch: expected %0b actual %0b",
                             $time, want.tested, tested);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return owed_verdicts.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block hookup
    // ------------------------------------------------------------------------
    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CW-1:0]          cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // low bit up: v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    // low bit up: poly_flags, two_sided, object_culled
    logic [IN_USER_W-1:0]   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // low bit up: backface_out, zero fill
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    // low bit up: was_tested
    logic [OUT_USER_W-1:0]  m_axis_tuser;

    bit             steady = 1'b0;      // suppress idling on both sides
    int             cycles = 0;
    cull_scoreboard sb = new();

    triangle_backface_cull #(
        .COORD_WIDTH (CW)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sink: stall at random, except during the steady stretch
    always @(posedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: check every result item accepted at this edge
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata[0], m_axis_tuser[0]);
        end
    end

    // Watchdog: end a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic vertex_t vtx(int x, int y, int z);
        vertex_t p;
        p.x = CW'(x);
        p.y = CW'(y);
        p.z = CW'(z);
        return p;
    endfunction

    function automatic triangle_t make_tri(vertex_t v0, vertex_t v1, vertex_t v2,
                                           logic [POLY_FLAGS_W-1:0] flags,
                                           logic two, logic culled);
        triangle_t t;
        t.v0            = v0;
        t.v1            = v1;
        t.v2            = v2;
        t.poly_flags    = flags;
        t.two_sided     = two;
        t.object_culled = culled;
        return t;
    endfunction

    // Mix extremes, coordinates near the origin and full-range values
    function automatic int pick_coord();
        case ($urandom_range(9))
            0: return C_MAX;
            1: return C_MIN;
            2: return 0;
            3, 4: return int'($urandom_range(8 * ONE)) - 4 * ONE;
            default: return int'($urandom());
        endcase
    endfunction

    function automatic vertex_t rand_vertex();
        return vtx(pick_coord(), pick_coord(), pick_coord());
    endfunction

    function automatic triangle_t rand_triangle();
        triangle_t t;
        t.v0 = rand_vertex();
        t.v1 = rand_vertex();
        t.v2 = rand_vertex();
        // fold in degenerate triangles and a camera lying on the first vertex
        case ($urandom_range(24))
            0: t.v2 = t.v1;
            1: t.v2 = t.v0;
            2: t.v0 = {sb.cam_z, sb.cam_y, sb.cam_x};
            default: ;
        endcase
        // most items must reach the dot-product test; the rest are random flags
        if ($urandom_range(99) < 75) begin
            t.poly_flags    = FL_ACTIVE;
            t.two_sided     = 1'b0;
            t.object_culled = 1'b0;
        end else begin
            t.poly_flags    = POLY_FLAGS_W'($urandom());
            t.two_sided     = 1'($urandom());
            t.object_culled = 1'($urandom());
        end
        return t;
    endfunction

    // Hand one triangle over; return at the edge that accepts it
    task automatic send_triangle(triangle_t t);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({t.v2, t.v1, t.v0});
        s_axis_tuser  <= {t.object_culled, t.two_sided, t.poly_flags};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_triangle(t);
    endtask

    // Drop valid and wait until every owed result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Write x, y, z back to back, then poke the unused index with junk
    task automatic load_camera(int x, int y, int z);
        logic [CFG_ADDR_W-1:0] addrs[4];
        logic [CW-1:0]         vals[4];
        addrs = '{CFG_CAM_X, CFG_CAM_Y, CFG_CAM_Z, CFG_UNUSED};
        vals  = '{CW'(x), CW'(y), CW'(z), CW'($urandom())};
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= addrs[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.set_camera(addrs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        vertex_t f0, f1, f2;
        int      ph;

        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= CFG_CAM_X;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, camera still at its reset origin.
        // Front-facing triangle in the plane z = -1, viewed from the origin.
        f0 = vtx(0, 0, -ONE);
        f1 = vtx(ONE, 0, -ONE);
        f2 = vtx(0, ONE, -ONE);
        send_triangle(make_tri(f0, f1, f2, FL_ACTIVE, 1'b0, 1'b0));
        // same triangle wound the other way
        send_triangle(make_tri(f0, f2, f1, FL_ACTIVE, 1'b0, 1'b0));
        // camera sits on the first vertex: grazing, marked backface
        send_triangle(make_tri(vtx(0, 0, 0), vtx(ONE, 0, 0), vtx(0, ONE, 0),
                               FL_ACTIVE, 1'b0, 1'b0));
        // camera in the triangle's plane but off the vertex
        send_triangle(make_tri(vtx(ONE, 0, 0), vtx(2 * ONE, 0, 0), vtx(ONE, ONE, 0),
                               FL_ACTIVE, 1'b0, 1'b0));
        // degenerate: all three vertices coincide
        send_triangle(make_tri(vtx(ONE, 2 * ONE, 3 * ONE), vtx(ONE, 2 * ONE, 3 * ONE),
                               vtx(ONE, 2 * ONE, 3 * ONE), FL_ACTIVE, 1'b0, 1'b0));
        // degenerate: collinear vertices
        send_triangle(make_tri(vtx(0, 0, ONE), vtx(ONE, ONE, ONE), vtx(2 * ONE, 2 * ONE, ONE),
                               FL_ACTIVE, 1'b0, 1'b0));
        // coordinate extremes, widest edge vectors
        send_triangle(make_tri(vtx(C_MIN, C_MIN, C_MIN), vtx(C_MAX, C_MIN, C_MIN),
                               vtx(C_MIN, C_MAX, C_MIN), FL_ACTIVE, 1'b0, 1'b0));
        send_triangle(make_tri(vtx(C_MAX, C_MAX, C_MAX), vtx(C_MIN, C_MAX, C_MAX),
                               vtx(C_MAX, C_MIN, C_MAX), FL_ACTIVE, 1'b0, 1'b0));
        send_triangle(make_tri(vtx(C_MIN, C_MAX, C_MIN), vtx(C_MAX, C_MIN, C_MAX),
                               vtx(C_MAX, C_MAX, C_MIN), FL_ACTIVE, 1'b0, 1'b0));
        send_triangle(make_tri(vtx(-1, -1, -1), vtx(C_MAX, -1, C_MIN),
                               vtx(C_MIN, C_MAX, -1), FL_ACTIVE, 1'b0, 1'b0));
        // skipped tests, on front-facing geometry and last on the reversed winding: flags pass straight through
        send_triangle(make_tri(f0, f1, f2, FL_NONE, 1'b0, 1'b0));
        send_triangle(make_tri(f0, f1, f2, FL_CLIPPED, 1'b0, 1'b0));
        send_triangle(make_tri(f0, f1, f2, FL_BACK, 1'b0, 1'b0));
        send_triangle(make_tri(f0, f1, f2, FL_ACTIVE | FL_CLIPPED, 1'b0, 1'b0));
        send_triangle(make_tri(f0, f1, f2, FL_ACTIVE | FL_BACK, 1'b0, 1'b0));
        send_triangle(make_tri(f0, f1, f2, FL_ACTIVE | FL_CLIPPED | FL_BACK, 1'b0, 1'b0));
        send_triangle(make_tri(f0, f1, f2, FL_ACTIVE, 1'b1, 1'b0));
        send_triangle(make_tri(f0, f1, f2, FL_ACTIVE, 1'b0, 1'b1));
        send_triangle(make_tri(f0, f1, f2, FL_ACTIVE | FL_BACK, 1'b1, 1'b1));
        send_triangle(make_tri(f0, f2, f1, FL_NONE | FL_BACK, 1'b0, 1'b1));

        // Random phases, each behind a fresh camera; extremes come first.
        // Phase 2 runs with no idling on either side.
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: load_camera(C_MAX, C_MAX, C_MAX);
                1: load_camera(C_MIN, C_MIN, C_MIN);
                2: load_camera(C_MAX, C_MIN, 0);
                3: load_camera(int'($urandom_range(8 * ONE)) - 4 * ONE,
                               int'($urandom_range(8 * ONE)) - 4 * ONE,
                               int'($urandom_range(8 * ONE)) - 4 * ONE);
                default: load_camera(int'($urandom()), int'($urandom()), int'($urandom()));
            endcase
            steady <= (ph == 2);
            repeat (PHASE_ITEMS) send_triangle(rand_triangle());
        end

        // Wait out the pipe, then give stray items a chance to show up
        drain();
        repeat (NUM_STAGES + 4) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
